// ===== rtl/ftvi_pkg.sv =====
// Shared types, constants and helpers for the fuzzy truth-value inference core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ftvi_pkg;

    localparam int DEF_MAX_ATTRS   = 8;
    localparam int DEF_SETS        = 16;
    localparam int DEF_POINTS      = 16;
    localparam int DEF_TRUTH_STEPS = 257;

    localparam int VAL_W = 16;
    localparam logic [VAL_W-1:0] ONE_Q = 16'd32768;

    localparam int OP_W = 5;    // out_points register width
    localparam int DIVIDEND_W = 31;
    localparam int DIVISOR_W  = 16;

    typedef enum logic [2:0] {
        CMD_ANT   = 3'd0,
        CMD_CONS  = 3'd1,
        CMD_OBS   = 3'd2,
        CMD_TERM  = 3'd3,
        CMD_EMIT  = 3'd4,
        CMD_COUNT = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_RD,
        ST_B_SEG,
        ST_B_MUL,
        ST_B_DSTART,
        ST_B_DIV,
        ST_B_NEXT,
        ST_B_WR,
        ST_R_BRD,
        ST_R_BWAIT,
        ST_R_RD,
        ST_R_ACC,
        ST_R_ROW,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // divider request and status
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    function automatic int clog2p(input int n);
        return (n <= 2) ? 1 : $clog2(n);
    endfunction

    function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

endpackage

// ===== rtl/ftvi_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ftvi_pkg for the request and status structs.
`timescale 1ns / 1ps
module ftvi_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  ftvi_pkg::div_req_t req,
    output ftvi_pkg::div_rsp_t rsp
);
    import ftvi_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    // one shift-compare-subtract step per cycle
    always_comb begin
        logic [DIVISOR_W:0] rem_sh;
        rem_sh    = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/fuzzy_truth_value_inference_core.sv =====
// Top level: command decode, set memories, sequencer and result stream.
// Depends on ftvi_pkg and ftvi_divider.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | s_tdata (cmd..value), s_tlast = last_term
//  m_      | out | m_tvalid/tready  | m_tdata (out_index, membership), m_tlast = last
//  cfg     | in  | cfg_wr_en        | cfg_wr_data = out_points
//
// Point, count and unknown words are taken in idle. A rule term walks TRUTH_STEPS
// levels (first point read, truth write), plus per further segment a multiply and
// a divide when the level lies in it (shared 31-step divider), else a skip; then
// a sweep over all TRUTH_STEPS levels per result point. Emit streams out_points
// result words, stalling on m_tready. s_tready is low while busy.
// Reset is synchronous active low; set memories hold no reset value.
`timescale 1ns / 1ps
module fuzzy_truth_value_inference_core #(
    parameter int MAX_ATTRS   = ftvi_pkg::DEF_MAX_ATTRS,
    parameter int SETS        = ftvi_pkg::DEF_SETS,
    parameter int POINTS      = ftvi_pkg::DEF_POINTS,
    parameter int TRUTH_STEPS = ftvi_pkg::DEF_TRUTH_STEPS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cmd[2:0] attr[5:3] set_index[9:6] cons_index[13:10] point_index[17:14]
    // value[33:18], zero pad
    input  logic [39:0]            s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_index[3:0] membership[19:4], zero pad
    output logic [23:0]            m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [ftvi_pkg::OP_W-1:0] cfg_wr_data
);
    import ftvi_pkg::*;

    localparam int A_DEPTH = MAX_ATTRS * SETS * POINTS;
    localparam int C_DEPTH = SETS * POINTS;
    localparam int O_DEPTH = MAX_ATTRS * POINTS;
    localparam int AAW = clog2p(A_DEPTH);
    localparam int CAW = clog2p(C_DEPTH);
    localparam int OAW = clog2p(O_DEPTH);
    localparam int TIW = clog2p(TRUTH_STEPS);
    localparam int PIW = clog2p(POINTS);
    localparam int JW  = clog2p(POINTS + 1);
    localparam int ATW = clog2p(MAX_ATTRS);
    localparam int SW  = clog2p(SETS);
    localparam int LVL_D = TRUTH_STEPS - 1;
    localparam int LVL_Q = 32768 / LVL_D;
    localparam int LVL_R = 32768 % LVL_D;
    localparam int RW  = clog2p(2 * LVL_D + 1);

    // input word fields
    logic [2:0]       in_cmd;
    logic [2:0]       in_attr;
    logic [3:0]       in_set;
    logic [3:0]       in_cons;
    logic [3:0]       in_pt;
    logic [VAL_W-1:0] in_value;
    logic             accept;

    assign in_cmd   = s_tdata[2:0];
    assign in_attr  = s_tdata[5:3];
    assign in_set   = s_tdata[9:6];
    assign in_cons  = s_tdata[13:10];
    assign in_pt    = s_tdata[17:14];
    assign in_value = s_tdata[33:18];

    state_t state_reg, state_next;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // memories
    logic [VAL_W-1:0] ant_mem   [A_DEPTH];
    logic [VAL_W-1:0] cons_mem  [C_DEPTH];
    logic [VAL_W-1:0] obs_mem   [O_DEPTH];
    logic [VAL_W-1:0] truth_mem [TRUTH_STEPS];
    logic [VAL_W-1:0] ant_rd_reg, cons_rd_reg, obs_rd_reg, truth_rd_reg;
    logic [AAW-1:0]   ant_wr_addr, ant_rd_addr;
    logic [CAW-1:0]   cons_wr_addr, cons_rd_addr;
    logic [OAW-1:0]   obs_wr_addr, obs_rd_addr;
    logic             ant_ok, cons_ok, obs_ok, term_ok, cnt_ok;

    // small state
    logic [JW-1:0]    pc_reg [MAX_ATTRS];
    logic [VAL_W-1:0] row_reg [POINTS];
    logic [VAL_W-1:0] res_reg [POINTS];
    logic [OP_W-1:0]  op_reg;

    // sequencer registers
    logic [TIW-1:0]   ti_reg, ti_next;
    logic [VAL_W-1:0] lvl_reg, lvl_next;
    logic [RW-1:0]    lrem_reg, lrem_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [JW-1:0]    cnt_reg, cnt_next;
    logic [ATW-1:0]   attr_reg, attr_next;
    logic [SW-1:0]    set_reg, set_next;
    logic [SW-1:0]    cons_reg, cons_next;
    logic             lastt_reg, lastt_next;
    logic [VAL_W-1:0] prev_a_reg, prev_a_next, prev_o_reg, prev_o_next;
    logic [VAL_W-1:0] cur_a_reg, cur_a_next, cur_o_reg, cur_o_next;
    logic [VAL_W-1:0] dt_reg, dt_next, do_reg, do_next, dv_reg, dv_next;
    logic             neg_reg, neg_next;
    logic [31:0]      prod_reg, prod_next;
    logic [VAL_W-1:0] best_reg, best_next;
    logic [VAL_W-1:0] b_reg, b_next;
    logic [VAL_W-1:0] m_reg, m_next;

    // output register
    logic             mv_reg, mv_next;
    logic [3:0]       mi_reg, mi_next;
    logic [VAL_W-1:0] mm_reg, mm_next;
    logic             ml_reg, ml_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    ftvi_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // address decode and range checks
    assign ant_ok  = (int'(in_attr) < MAX_ATTRS) && (int'(in_set) < SETS)
                     && (int'(in_pt) < POINTS);
    assign cons_ok = (int'(in_set) < SETS) && (int'(in_pt) < POINTS);
    assign obs_ok  = (int'(in_attr) < MAX_ATTRS) && (int'(in_pt) < POINTS);
    assign term_ok = (int'(in_attr) < MAX_ATTRS) && (int'(in_set) < SETS)
                     && (int'(in_cons) < SETS);
    assign cnt_ok  = (int'(in_attr) < MAX_ATTRS);

    assign ant_wr_addr  = AAW'(int'(in_attr) * SETS * POINTS + int'(in_set) * POINTS
                               + int'(in_pt));
    assign cons_wr_addr = CAW'(int'(in_set) * POINTS + int'(in_pt));
    assign obs_wr_addr  = OAW'(int'(in_attr) * POINTS + int'(in_pt));
    assign ant_rd_addr  = AAW'(int'(attr_reg) * SETS * POINTS + int'(set_reg) * POINTS
                               + int'(j_reg));
    assign obs_rd_addr  = OAW'(int'(attr_reg) * POINTS + int'(j_reg));
    assign cons_rd_addr = CAW'(int'(cons_reg) * POINTS + int'(j_reg));

    // set memories: write on accepted point words, registered read
    always_ff @(posedge aclk) begin
        if (accept && in_cmd == CMD_ANT && ant_ok)
            ant_mem[ant_wr_addr] <= sat_one(in_value);
        if (accept && in_cmd == CMD_CONS && cons_ok)
            cons_mem[cons_wr_addr] <= sat_one(in_value);
        if (accept && in_cmd == CMD_OBS && obs_ok)
            obs_mem[obs_wr_addr] <= sat_one(in_value);
        ant_rd_reg  <= ant_mem[ant_rd_addr];
        obs_rd_reg  <= obs_mem[obs_rd_addr];
        cons_rd_reg <= cons_mem[cons_rd_addr];
    end

    // truth-value memory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_B_WR)
            truth_mem[ti_reg] <= best_reg;
        truth_rd_reg <= truth_mem[ti_reg];
    end

    // sequencer: next state and datapath
    always_comb begin
        logic [RW-1:0]      rsum;
        logic [VAL_W-1:0]   lvl_adv;
        logic [RW-1:0]      rem_adv;
        logic               in_seg;
        logic [VAL_W:0]     y;
        logic [VAL_W+1:0]   imp;
        logic [VAL_W-1:0]   imp_s, v;

        rsum = lrem_reg + RW'(LVL_R);
        if (rsum >= RW'(LVL_D)) begin
            lvl_adv = lvl_reg + VAL_W'(LVL_Q + 1);
            rem_adv = rsum - RW'(LVL_D);
        end else begin
            lvl_adv = lvl_reg + VAL_W'(LVL_Q);
            rem_adv = rsum;
        end
        in_seg = ((lvl_reg >= ant_rd_reg) && (lvl_reg <= prev_a_reg))
              || ((lvl_reg <= ant_rd_reg) && (lvl_reg >= prev_a_reg));
        y = neg_reg ? ({1'b0, prev_o_reg} - {1'b0, div_rsp.quotient[VAL_W-1:0]})
                    : ({1'b0, prev_o_reg} + {1'b0, div_rsp.quotient[VAL_W-1:0]});
        imp   = {2'b0, ONE_Q} - {2'b0, lvl_reg} + {2'b0, b_reg};
        imp_s = (imp > {2'b0, ONE_Q}) ? ONE_Q : imp[VAL_W-1:0];
        v     = (imp_s < truth_rd_reg) ? imp_s : truth_rd_reg;

        state_next  = state_reg;
        ti_next     = ti_reg;
        lvl_next    = lvl_reg;
        lrem_next   = lrem_reg;
        j_next      = j_reg;
        cnt_next    = cnt_reg;
        attr_next   = attr_reg;
        set_next    = set_reg;
        cons_next   = cons_reg;
        lastt_next  = lastt_reg;
        prev_a_next = prev_a_reg;
        prev_o_next = prev_o_reg;
        cur_a_next  = cur_a_reg;
        cur_o_next  = cur_o_reg;
        dt_next     = dt_reg;
        do_next     = do_reg;
        dv_next     = dv_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        best_next   = best_reg;
        b_next      = b_reg;
        m_next      = m_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg[DIVIDEND_W-1:0];
        div_req.divisor  = dv_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && in_cmd == CMD_TERM && term_ok) begin
                    attr_next  = ATW'(in_attr);
                    set_next   = SW'(in_set);
                    cons_next  = SW'(in_cons);
                    lastt_next = s_tlast;
                    cnt_next   = pc_reg[ATW'(in_attr)];
                    ti_next    = '0;
                    lvl_next   = '0;
                    lrem_next  = '0;
                    j_next     = '0;
                    best_next  = '0;
                    state_next = (pc_reg[ATW'(in_attr)] < JW'(2)) ? ST_B_WR : ST_B_RD;
                end else if (accept && in_cmd == CMD_EMIT) begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_B_RD: state_next = ST_B_SEG;
            ST_B_SEG: begin
                cur_a_next = ant_rd_reg;
                cur_o_next = obs_rd_reg;
                if (j_reg == '0) begin
                    prev_a_next = ant_rd_reg;
                    prev_o_next = obs_rd_reg;
                    j_next      = JW'(1);
                    state_next  = ST_B_RD;
                end else if (ant_rd_reg != prev_a_reg && in_seg) begin
                    dt_next  = (lvl_reg >= prev_a_reg) ? lvl_reg - prev_a_reg
                                                       : prev_a_reg - lvl_reg;
                    do_next  = (obs_rd_reg >= prev_o_reg) ? obs_rd_reg - prev_o_reg
                                                          : prev_o_reg - obs_rd_reg;
                    dv_next  = (ant_rd_reg >= prev_a_reg) ? ant_rd_reg - prev_a_reg
                                                          : prev_a_reg - ant_rd_reg;
                    neg_next = (lvl_reg < prev_a_reg) ^ (obs_rd_reg < prev_o_reg)
                               ^ (ant_rd_reg < prev_a_reg);
                    state_next = ST_B_MUL;
                end else begin
                    state_next = ST_B_NEXT;
                end
            end
            ST_B_MUL: begin
                prod_next  = dt_reg * do_reg;
                state_next = ST_B_DSTART;
            end
            ST_B_DSTART: begin
                div_req.start = 1'b1;
                state_next    = ST_B_DIV;
            end
            ST_B_DIV: begin
                if (div_rsp.done) begin
                    if (y[VAL_W-1:0] > best_reg)
                        best_next = y[VAL_W-1:0];
                    state_next = ST_B_NEXT;
                end
            end
            ST_B_NEXT: begin
                prev_a_next = cur_a_reg;
                prev_o_next = cur_o_reg;
                if (j_reg == cnt_reg - 1'b1) begin
                    state_next = ST_B_WR;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_B_RD;
                end
            end
            ST_B_WR: begin
                j_next    = '0;
                best_next = '0;
                if (ti_reg == TIW'(TRUTH_STEPS - 1)) begin
                    state_next = ST_R_BRD;
                end else begin
                    ti_next    = ti_reg + 1'b1;
                    lvl_next   = lvl_adv;
                    lrem_next  = rem_adv;
                    state_next = (cnt_reg < JW'(2)) ? ST_B_WR : ST_B_RD;
                end
            end
            ST_R_BRD: state_next = ST_R_BWAIT;
            ST_R_BWAIT: begin
                b_next     = cons_rd_reg;
                ti_next    = '0;
                lvl_next   = '0;
                lrem_next  = '0;
                m_next     = '0;
                state_next = ST_R_RD;
            end
            ST_R_RD: state_next = ST_R_ACC;
            ST_R_ACC: begin
                if (v > m_reg)
                    m_next = v;
                if (ti_reg == TIW'(TRUTH_STEPS - 1)) begin
                    state_next = ST_R_ROW;
                end else begin
                    ti_next    = ti_reg + 1'b1;
                    lvl_next   = lvl_adv;
                    lrem_next  = rem_adv;
                    state_next = ST_R_RD;
                end
            end
            ST_R_ROW: begin
                if (int'(j_reg) == int'(op_reg) - 1) begin
                    state_next = lastt_reg ? ST_FOLD : ST_IDLE;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_R_BRD;
                end
            end
            ST_FOLD: state_next = ST_IDLE;
            ST_EMIT: begin
                if (!mv_reg || m_tready) begin
                    if (int'(j_reg) == int'(op_reg) - 1)
                        state_next = ST_IDLE;
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // output register
        mv_next = mv_reg && !m_tready;
        mi_next = mi_reg;
        mm_next = mm_reg;
        ml_next = ml_reg;
        if (state_reg == ST_EMIT && (!mv_reg || m_tready)) begin
            mv_next = 1'b1;
            mi_next = 4'(j_reg);
            mm_next = res_reg[PIW'(j_reg)];
            ml_next = (int'(j_reg) == int'(op_reg) - 1);
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            op_reg    <= OP_W'((POINTS < 16) ? POINTS : 16);
            for (int k = 0; k < MAX_ATTRS; k++)
                pc_reg[k] <= JW'(POINTS);
            for (int k = 0; k < POINTS; k++) begin
                row_reg[k] <= '0;
                res_reg[k] <= ONE_Q;
            end
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (cfg_wr_en) begin
                if (cfg_wr_data == '0)
                    op_reg <= OP_W'(1);
                else if (int'(cfg_wr_data) > POINTS)
                    op_reg <= OP_W'(POINTS);
                else
                    op_reg <= cfg_wr_data;
            end
            if (accept && in_cmd == CMD_COUNT && cnt_ok)
                pc_reg[ATW'(in_attr)] <= (in_value > VAL_W'(POINTS)) ? JW'(POINTS)
                                                                     : JW'(in_value);
            if (state_reg == ST_R_ROW && m_reg > row_reg[PIW'(j_reg)])
                row_reg[PIW'(j_reg)] <= m_reg;
            if (state_reg == ST_FOLD) begin
                for (int k = 0; k < POINTS; k++) begin
                    if (k < int'(op_reg) && row_reg[k] < res_reg[k])
                        res_reg[k] <= row_reg[k];
                    row_reg[k] <= '0;
                end
            end
            if (state_reg == ST_EMIT && (!mv_reg || m_tready))
                res_reg[PIW'(j_reg)] <= ONE_Q;
        end
        ti_reg     <= ti_next;
        lvl_reg    <= lvl_next;
        lrem_reg   <= lrem_next;
        j_reg      <= j_next;
        cnt_reg    <= cnt_next;
        attr_reg   <= attr_next;
        set_reg    <= set_next;
        cons_reg   <= cons_next;
        lastt_reg  <= lastt_next;
        prev_a_reg <= prev_a_next;
        prev_o_reg <= prev_o_next;
        cur_a_reg  <= cur_a_next;
        cur_o_reg  <= cur_o_next;
        dt_reg     <= dt_next;
        do_reg     <= do_next;
        dv_reg     <= dv_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        best_reg   <= best_next;
        b_reg      <= b_next;
        m_reg      <= m_next;
        mi_reg     <= mi_next;
        mm_reg     <= mm_next;
        ml_reg     <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'b0, mm_reg, mi_reg};
    assign m_tlast  = ml_reg;

    // divider only runs while the sequencer waits on it
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == ST_B_DIV))
        else $error("divider busy outside divide wait");

    // emitted membership never exceeds one
    a_memb_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (mm_reg <= ONE_Q))
        else $error("membership above one");

    // out_points stays within its clamp
    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg != '0) && (int'(op_reg) <= POINTS))
        else $error("out_points out of range");

    // the segment walk never passes the point count
    a_seg_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_SEG) |-> (j_reg < cnt_reg))
        else $error("segment index past point count");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for fuzzy_truth_value_inference_core: loads sets, runs rule terms
// and emits, and compares every result word with an in-bench predictor of the core.
// Depends on ftvi_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
    import ftvi_pkg::*;

    localparam int ATTRS = 8;
    localparam int NSETS = 16;
    localparam int NPTS  = 16;
    localparam int STEPS = 257;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [3:0]  idx;
        logic [15:0] memb;
        logic        last;
    } point_word_t;

    typedef struct {
        logic [39:0] data;
        logic        last;
    } cmd_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;

    fuzzy_truth_value_inference_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] p_ant [ATTRS][NSETS][NPTS];
    logic [15:0] p_cons [NSETS][NPTS];
    logic [15:0] p_obs [ATTRS][NPTS];
    logic [4:0]  p_count [ATTRS];
    logic [15:0] p_truth [STEPS];
    logic [15:0] p_row [NPTS];
    logic [15:0] p_acc [NPTS];
    int          p_npoints;

    // generator bookkeeping: which entries are written, counts as they will be
    bit ant_done [ATTRS][NSETS][NPTS];
    bit cons_done [NSETS][NPTS];
    bit obs_done [ATTRS][NPTS];
    int g_count [ATTRS];
    int g_npoints;

    cmd_word_t   pending_words[$];
    point_word_t expected_points[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        took = 1'b0;

    function automatic logic [15:0] clip_one(input longint v);
        return (v > 32768) ? 16'd32768 : v[15:0];
    endfunction

    function automatic longint level(input int ti);
        return (longint'(ti) * 32768) / (STEPS - 1);
    endfunction

    // truth value of one antecedent against its observation, then sup-min into the row
    function automatic void run_term(input int at, input int st, input int cs);
        longint t, a1, a2, y, imp;
        logic [15:0] best, m, v;
        for (int ti = 0; ti < STEPS; ti++) begin
            t = level(ti);
            best = '0;
            for (int j = 0; j + 1 < int'(p_count[at]); j++) begin
                a1 = p_ant[at][st][j];
                a2 = p_ant[at][st][j+1];
                if (a1 == a2) continue;
                if ((t - a1) * (a2 - t) < 0) continue;
                y = longint'(p_obs[at][j]) + ((t - a1) *
                    (longint'(p_obs[at][j+1]) - longint'(p_obs[at][j]))) / (a2 - a1);
                if (y < 0) y = 0;
                if (y > best) best = clip_one(y);
            end
            p_truth[ti] = best;
        end
        for (int j = 0; j < p_npoints; j++) begin
            m = '0;
            for (int ti = 0; ti < STEPS; ti++) begin
                imp = 32768 - level(ti) + p_cons[cs][j];
                if (imp > 32768) imp = 32768;
                v = p_truth[ti];
                if (imp < v) v = imp[15:0];
                if (v > m) m = v;
            end
            if (m > p_row[j]) p_row[j] = m;
        end
    endfunction

    function automatic void apply_word(input logic [39:0] d, input logic lt);
        logic [2:0] c;
        int at, st, cs, pt;
        logic [15:0] val;
        point_word_t pw;
        c = d[2:0];
        at = int'(d[5:3]);
        st = int'(d[9:6]);
        cs = int'(d[13:10]);
        pt = int'(d[17:14]);
        val = d[33:18];
        case (c)
            CMD_ANT: p_ant[at][st][pt] = clip_one(val);
            CMD_CONS: p_cons[st][pt] = clip_one(val);
            CMD_OBS: p_obs[at][pt] = clip_one(val);
            CMD_COUNT: p_count[at] = (val > 16'(NPTS)) ? 5'(NPTS) : val[4:0];
            CMD_TERM: begin
                run_term(at, st, cs);
                if (lt) begin
                    for (int j = 0; j < p_npoints; j++)
                        if (p_row[j] < p_acc[j]) p_acc[j] = p_row[j];
                    for (int j = 0; j < NPTS; j++) p_row[j] = '0;
                end
            end
            CMD_EMIT: begin
                for (int j = 0; j < p_npoints; j++) begin
                    pw.idx = 4'(j);
                    pw.memb = p_acc[j];
                    pw.last = (j + 1 == p_npoints);
                    expected_points.push_back(pw);
                    p_acc[j] = 16'd32768;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // input acceptance and result check at the rising edge
    always @(posedge aclk) begin
        point_word_t want;
        took <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) apply_word(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            end else begin
                want = expected_points.pop_front();
                if (m_tdata[3:0] !== want.idx)
                    report_mismatch($sformatf("out_index %0d, want %0d", m_tdata[3:0], want.idx));
                if (m_tdata[19:4] !== want.memb)
                    report_mismatch($sformatf("membership %0d at %0d, want %0d",
                                              m_tdata[19:4], want.idx, want.memb));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b at %0d, want %b",
                                              m_tlast, want.idx, want.last));
            end
        end
    end

    // word driver and result stall, both at the falling edge
    always @(negedge aclk) begin
        cmd_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (s_tvalid && !took) begin
                // hold the word until accepted
            end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= w.data;
                s_tlast <= w.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic put(input logic [2:0] c, input int at, input int st, input int cs,
                       input int pt, input int val, input bit lt);
        cmd_word_t w;
        w.data = {6'd0, val[15:0], pt[3:0], cs[3:0], st[3:0], at[2:0], c};
        w.last = lt;
        pending_words.push_back(w);
        if (c == CMD_ANT) ant_done[at][st][pt] = 1;
        if (c == CMD_CONS) cons_done[st][pt] = 1;
        if (c == CMD_OBS) obs_done[at][pt] = 1;
        if (c == CMD_COUNT) g_count[at] = (val > NPTS) ? NPTS : val;
    endtask

    function automatic int rand_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) return $urandom_range(65535);
        if (r == 1) return 32768;
        if (r == 2) return 0;
        return $urandom_range(32768);
    endfunction

    // rule term, preceded by writes of any point it reads that is still unwritten
    task automatic put_term(input int at, input int st, input int cs, input bit lt);
        for (int j = 0; j < g_count[at]; j++) begin
            if (!ant_done[at][st][j]) put(CMD_ANT, at, st, 0, j, rand_value(), 0);
            if (!obs_done[at][j]) put(CMD_OBS, at, 0, 0, j, rand_value(), 0);
        end
        for (int j = 0; j < g_npoints; j++)
            if (!cons_done[cs][j]) put(CMD_CONS, 0, cs, 0, j, rand_value(), 0);
        put(CMD_TERM, at, st, cs, 0, $urandom_range(65535), lt);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_npoints(input logic [4:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        g_npoints = (v < 1) ? 1 : (v > NPTS) ? NPTS : int'(v);
        p_npoints = g_npoints;
    endtask

    task automatic random_words(input int n);
        int r, at;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            at = $urandom_range(ATTRS - 1);
            if (r < 12)
                put(CMD_ANT, at, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                    rand_value(), $urandom_range(1));
            else if (r < 20)
                put(CMD_CONS, at, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                    rand_value(), $urandom_range(1));
            else if (r < 28)
                put(CMD_OBS, at, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                    rand_value(), $urandom_range(1));
            else if (r < 38)
                put(CMD_COUNT, at, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                    ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(2, 6),
                    $urandom_range(1));
            else if (r < 42)
                put($urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7, at, $urandom_range(15),
                    $urandom_range(15), $urandom_range(15), $urandom_range(65535),
                    $urandom_range(1));
            else if (r < 75)
                put_term($urandom_range(3), $urandom_range(1), $urandom_range(1),
                         $urandom_range(2) != 0);
            else
                put(CMD_EMIT, at, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                    $urandom_range(65535), $urandom_range(1));
        end
        // close the phase with an emit so the core is idle once its words are back
        put(CMD_EMIT, 0, 0, 0, 0, 0, 0);
    endtask

    initial begin
        for (int a = 0; a < ATTRS; a++) begin
            p_count[a] = 5'(NPTS);
            g_count[a] = NPTS;
        end
        for (int j = 0; j < STEPS; j++) p_truth[j] = '0;
        for (int j = 0; j < NPTS; j++) begin
            p_row[j] = '0;
            p_acc[j] = 16'd32768;
        end
        p_npoints = NPTS;
        g_npoints = NPTS;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase 0: directed, no idling, widest result
        write_npoints(5'd31);
        put(CMD_RSVD6, 7, 15, 15, 15, 65535, 1);
        put(CMD_RSVD7, 0, 0, 0, 0, 0, 0);
        put(CMD_ANT, 7, 15, 0, 15, 65535, 0);
        put(CMD_ANT, 7, 15, 0, 15, 0, 0);
        put(CMD_CONS, 0, 15, 0, 15, 40000, 0);
        put(CMD_OBS, 7, 0, 0, 15, 32768, 0);
        put(CMD_COUNT, 0, 0, 0, 0, 0, 0);
        put(CMD_COUNT, 1, 0, 0, 0, 65535, 0);
        put(CMD_COUNT, 2, 0, 0, 0, 1, 0);
        put_term(0, 0, 0, 1);       // no segments: truth all zero
        put_term(2, 1, 0, 0);       // row left pending across the emit
        put(CMD_EMIT, 0, 0, 0, 0, 0, 0);
        // equal antecedent neighbors
        put(CMD_COUNT, 3, 0, 0, 0, 3, 0);
        put(CMD_ANT, 3, 2, 0, 0, 1000, 0);
        put(CMD_ANT, 3, 2, 0, 1, 1000, 0);
        put(CMD_ANT, 3, 2, 0, 2, 30000, 0);
        put_term(3, 2, 0, 1);
        put(CMD_EMIT, 0, 0, 0, 0, 0, 1);
        put(CMD_EMIT, 0, 0, 0, 0, 0, 0);   // back to all ones
        random_words(5);
        wait_drained();

        // phase 1: sender idles
        send_idle_pct = 52;
        write_npoints(5'd1);
        random_words(5);
        wait_drained();

        // phase 2: receiver stalls
        send_idle_pct = 0;
        recv_stall_pct = 52;
        write_npoints(5'd0);
        random_words(5);
        wait_drained();

        // phase 3: both
        send_idle_pct = 28;
        recv_stall_pct = 28;
        write_npoints(5'($urandom_range(2, 15)));
        random_words(5);
        wait_drained();

        if (errors == 0 && expected_points.size() == 0)
            $display("fuzzy_truth_value_inference_core test passed");
        else
            $display("fuzzy_truth_value_inference_core test failed");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("fuzzy_truth_value_inference_core test failed");
        $finish;
    end

endmodule
